FILE: rtl/mecanum_wheel_speed_mixer_assert.svh
// ============================================================================
// Assertion macros for the mecanum wheel speed mixer
// Shared property forms; the including scope provides i_clk and i_rst_n.
// ============================================================================
`ifndef MECANUM_WHEEL_SPEED_MIXER_ASSERT_SVH
`define MECANUM_WHEEL_SPEED_MIXER_ASSERT_SVH

// Same-cycle implication, ignored while in reset.
`define MSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked through reset as well.
`define MSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/msm_pkg.sv
// ============================================================================
// msm_pkg
// Types and constants shared by the mecanum wheel speed mixer.
// ============================================================================
package msm_pkg;

    localparam int VEL_W        = 16;
    localparam int REG_W        = 15;
    localparam int MIX_W        = 18;
    localparam int MAG_W        = 17;
    localparam int PROD_W       = MAG_W + REG_W;
    localparam int Q_W          = REG_W;
    localparam int NUM_WHEELS   = 4;
    localparam int FRONT_STAGES = 3;
    localparam int LATENCY      = FRONT_STAGES + 1 + Q_W + 1;
    localparam int CFG_IDX_W    = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_LIMIT_X   = 3'd0;
    localparam t_cfg_idx CFG_LIMIT_Y   = 3'd1;
    localparam t_cfg_idx CFG_LIMIT_ROT = 3'd2;
    localparam t_cfg_idx CFG_WHEEL_MAX = 3'd3;

    localparam logic [REG_W-1:0] RESET_REG = 15'd8000;

    typedef struct packed {
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] vel_rot;
    } t_cmd;

    typedef struct packed {
        logic signed [VEL_W-1:0] wheel_a;
        logic signed [VEL_W-1:0] wheel_b;
        logic signed [VEL_W-1:0] wheel_c;
        logic signed [VEL_W-1:0] wheel_d;
    } t_wheels;

    typedef struct packed {
        logic [REG_W-1:0] limit_x;
        logic [REG_W-1:0] limit_y;
        logic [REG_W-1:0] limit_rot;
        logic [REG_W-1:0] wheel_max;
    } t_cfg;

    // Front end result: wheel signs, magnitudes and the largest magnitude.
    typedef struct packed {
        logic                                valid;
        logic [NUM_WHEELS-1:0]               neg;
        logic [NUM_WHEELS-1:0][MAG_W-1:0]    mag;
        logic [MAG_W-1:0]                    max_abs;
    } t_front;

    // Back end result: signs and final magnitudes.
    typedef struct packed {
        logic                                valid;
        logic [NUM_WHEELS-1:0]               neg;
        logic [NUM_WHEELS-1:0][Q_W-1:0]      mag;
    } t_scaled;

endpackage

FILE: rtl/msm_front.sv
// ============================================================================
// msm_front
// Clamp, mix and peak-magnitude stages (three register stages).
// ============================================================================
module msm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  msm_pkg::t_cmd        i_cmd,
    input  msm_pkg::t_cfg        i_cfg,
    output msm_pkg::t_front      o_front
);

    function automatic logic signed [msm_pkg::VEL_W-1:0] clamp_sym(
        input logic signed [msm_pkg::VEL_W-1:0] v,
        input logic [msm_pkg::REG_W-1:0]        lim
    );
        logic signed [msm_pkg::VEL_W-1:0] l;
        l = $signed({1'b0, lim});
        if (v > l) begin
            return l;
        end else if (v < -l) begin
            return -l;
        end
        return v;
    endfunction

    // stage 1: clamped components
    logic                              r_s1_valid;
    logic signed [msm_pkg::VEL_W-1:0]  r_s1_x, r_s1_y, r_s1_w;

    // stage 2: per-wheel sign and magnitude
    logic                                                  r_s2_valid;
    logic [msm_pkg::NUM_WHEELS-1:0]                        r_s2_neg;
    logic [msm_pkg::NUM_WHEELS-1:0][msm_pkg::MAG_W-1:0]    r_s2_mag;
    logic [msm_pkg::NUM_WHEELS-1:0]                        n_s2_neg;
    logic [msm_pkg::NUM_WHEELS-1:0][msm_pkg::MAG_W-1:0]    n_s2_mag;

    // stage 3: registered output
    logic                                                  r_s3_valid;
    logic [msm_pkg::NUM_WHEELS-1:0]                        r_s3_neg;
    logic [msm_pkg::NUM_WHEELS-1:0][msm_pkg::MAG_W-1:0]    r_s3_mag;
    logic [msm_pkg::MAG_W-1:0]                             r_s3_max;
    logic [msm_pkg::MAG_W-1:0]         n_max01, n_max23, n_max;

    logic signed [msm_pkg::MIX_W-1:0]  sx, sy, sw;
    logic signed [msm_pkg::MIX_W-1:0]  sp [msm_pkg::NUM_WHEELS];
    logic        [msm_pkg::MIX_W-1:0]  sp_neg [msm_pkg::NUM_WHEELS];

    always_comb begin
        sx = {{(msm_pkg::MIX_W-msm_pkg::VEL_W){r_s1_x[msm_pkg::VEL_W-1]}}, r_s1_x};
        sy = {{(msm_pkg::MIX_W-msm_pkg::VEL_W){r_s1_y[msm_pkg::VEL_W-1]}}, r_s1_y};
        sw = {{(msm_pkg::MIX_W-msm_pkg::VEL_W){r_s1_w[msm_pkg::VEL_W-1]}}, r_s1_w};
        sp[0] =  sx - sy + sw;
        sp[1] =  sx + sy + sw;
        sp[2] = -sx + sy + sw;
        sp[3] = -sx - sy + sw;
        for (int l = 0; l < msm_pkg::NUM_WHEELS; l++) begin
            sp_neg[l]   = -sp[l];
            n_s2_neg[l] = sp[l][msm_pkg::MIX_W-1];
            n_s2_mag[l] = n_s2_neg[l] ? sp_neg[l][msm_pkg::MAG_W-1:0]
                                      : sp[l][msm_pkg::MAG_W-1:0];
        end
    end

    always_comb begin
        n_max01 = (r_s2_mag[0] > r_s2_mag[1]) ? r_s2_mag[0] : r_s2_mag[1];
        n_max23 = (r_s2_mag[2] > r_s2_mag[3]) ? r_s2_mag[2] : r_s2_mag[3];
        n_max   = (n_max01 > n_max23) ? n_max01 : n_max23;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
        end else begin
            r_s1_valid  <= i_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_x       <= clamp_sym(i_cmd.vel_x, i_cfg.limit_x);
        r_s1_y       <= clamp_sym(i_cmd.vel_y, i_cfg.limit_y);
        r_s1_w       <= clamp_sym(i_cmd.vel_rot, i_cfg.limit_rot);
        r_s2_neg     <= n_s2_neg;
        r_s2_mag     <= n_s2_mag;
        r_s3_neg     <= r_s2_neg;
        r_s3_mag     <= r_s2_mag;
        r_s3_max     <= n_max;
    end

    assign o_front = '{valid: r_s3_valid, neg: r_s3_neg, mag: r_s3_mag, max_abs: r_s3_max};

endmodule

FILE: rtl/msm_scale.sv
// ============================================================================
// msm_scale
// Product stage and a restoring divider, one quotient bit per stage.
// ============================================================================
module msm_scale (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  msm_pkg::t_front             i_front,
    input  logic [msm_pkg::REG_W-1:0]   i_wheel_max,
    output msm_pkg::t_scaled            o_scaled
);

    localparam int NW = msm_pkg::NUM_WHEELS;
    localparam int QW = msm_pkg::Q_W;

    // Index 0 is the product stage, index QW the last divider stage.
    logic                                      r_vld   [QW+1];
    logic                                      r_scale [QW+1];
    logic [NW-1:0]                             r_neg   [QW+1];
    logic [NW-1:0][QW-1:0]                     r_pass  [QW+1];
    logic [msm_pkg::MAG_W-1:0]                 r_div   [QW+1];
    logic [NW-1:0][msm_pkg::PROD_W-1:0]        r_rem   [QW+1];
    logic [NW-1:0][QW-1:0]                     r_quo   [QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_front.valid;
        end
    end

    // Unscaled magnitudes never exceed wheel_max, so QW bits hold them.
    always_ff @(posedge i_clk) begin
        r_scale[0] <= i_front.max_abs > {{(msm_pkg::MAG_W-msm_pkg::REG_W){1'b0}}, i_wheel_max};
        r_neg[0]   <= i_front.neg;
        r_div[0]   <= i_front.max_abs;
        for (int l = 0; l < NW; l++) begin
            r_pass[0][l] <= i_front.mag[l][QW-1:0];
            r_rem[0][l]  <= i_front.mag[l] * i_wheel_max;
            r_quo[0][l]  <= '0;
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_div
        localparam int K = QW - 1 - s;

        logic [NW-1:0][msm_pkg::PROD_W:0] n_sub;
        logic [msm_pkg::PROD_W:0]         dshift;

        always_comb begin
            dshift = {{(msm_pkg::PROD_W+1-msm_pkg::MAG_W){1'b0}}, r_div[s]} << K;
            for (int l = 0; l < NW; l++) begin
                n_sub[l] = {1'b0, r_rem[s][l]} - dshift;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_scale[s+1] <= r_scale[s];
            r_neg[s+1]   <= r_neg[s];
            r_pass[s+1]  <= r_pass[s];
            r_div[s+1]   <= r_div[s];
            for (int l = 0; l < NW; l++) begin
                r_quo[s+1][l] <= {r_quo[s][l][QW-2:0], ~n_sub[l][msm_pkg::PROD_W]};
                r_rem[s+1][l] <= n_sub[l][msm_pkg::PROD_W] ? r_rem[s][l]
                                                           : n_sub[l][msm_pkg::PROD_W-1:0];
            end
        end
    end

    always_comb begin
        o_scaled.valid = r_vld[QW];
        o_scaled.neg   = r_neg[QW];
        for (int l = 0; l < NW; l++) begin
            o_scaled.mag[l] = r_scale[QW] ? r_quo[QW][l] : r_pass[QW][l];
        end
    end

endmodule

FILE: rtl/mecanum_wheel_speed_mixer.sv
// ============================================================================
// mecanum_wheel_speed_mixer
// Mecanum inverse kinematics with proportional normalisation of wheel speeds.
// ============================================================================
// Usage:
//   Command channel: drive i_cmd (vel_x, vel_y, vel_rot) and raise start; the
//   transfer happens on a rising edge with start high and busy low. busy is
//   only high while i_rst_n is asserted, so a new command may follow every
//   cycle.
//   Result channel: o_result carries the four wheel speeds for exactly one
//   cycle, flagged by o_done. Results leave in command order, one per command.
//   Throughput: one per cycle, set by the fully pipelined path that each
//   command passes through in order: clamp, mix, peak search, one product
//   stage, fifteen divider stages (one quotient bit each), output
//   register.
//   The receiver cannot stall; nothing holds the pipeline.
//   Config: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 limit_x,
//   1 limit_y, 2 limit_rotation, 3 wheel_max); other indexes are dropped.
//   Write only with no command in flight.
//   Reset (synchronous, active low) empties the pipeline and loads 8000 into
//   all four registers.
// ============================================================================
module mecanum_wheel_speed_mixer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  msm_pkg::t_cmd                 i_cmd,
    input  logic                          i_cfg_we,
    input  msm_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [msm_pkg::REG_W-1:0]     i_cfg_data,
    output logic                          o_done,
    output msm_pkg::t_wheels              o_result
);

    msm_pkg::t_cfg     r_cfg;
    msm_pkg::t_front   front;
    msm_pkg::t_scaled  scaled;
    logic              accept;

    logic                            r_done;
    msm_pkg::t_wheels                r_result;
    logic signed [msm_pkg::VEL_W-1:0] n_wheel [msm_pkg::NUM_WHEELS];
    logic        [msm_pkg::VEL_W-1:0] mag16   [msm_pkg::NUM_WHEELS];

    // Only reset holds commands off.
    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.limit_x   <= msm_pkg::RESET_REG;
            r_cfg.limit_y   <= msm_pkg::RESET_REG;
            r_cfg.limit_rot <= msm_pkg::RESET_REG;
            r_cfg.wheel_max <= msm_pkg::RESET_REG;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                msm_pkg::CFG_LIMIT_X:   r_cfg.limit_x   <= i_cfg_data;
                msm_pkg::CFG_LIMIT_Y:   r_cfg.limit_y   <= i_cfg_data;
                msm_pkg::CFG_LIMIT_ROT: r_cfg.limit_rot <= i_cfg_data;
                msm_pkg::CFG_WHEEL_MAX: r_cfg.wheel_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp, mix and peak magnitude
    msm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_cmd   (i_cmd),
        .i_cfg   (r_cfg),
        .o_front (front)
    );

    // speed * wheel_max / max_abs where the peak is over the limit
    msm_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_front     (front),
        .i_wheel_max (r_cfg.wheel_max),
        .o_scaled    (scaled)
    );

    // Restore signs; division truncates toward zero so the sign just wraps
    // the magnitude.
    always_comb begin
        for (int l = 0; l < msm_pkg::NUM_WHEELS; l++) begin
            mag16[l]   = {1'b0, scaled.mag[l]};
            n_wheel[l] = scaled.neg[l] ? -$signed(mag16[l]) : $signed(mag16[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= scaled.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.wheel_a <= n_wheel[0];
        r_result.wheel_b <= n_wheel[1];
        r_result.wheel_c <= n_wheel[2];
        r_result.wheel_d <= n_wheel[3];
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

FILE: rtl/msm_checker.sv
// ============================================================================
// msm_checker
// Port-level checks for the mecanum wheel speed mixer, bound to the top.
// ============================================================================
`include "mecanum_wheel_speed_mixer_assert.svh"

module msm_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          i_cfg_we,
    input  msm_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [msm_pkg::REG_W-1:0]     i_cfg_data,
    input  logic                          o_done,
    input  msm_pkg::t_wheels              o_result
);

    logic [msm_pkg::REG_W-1:0] r_wmax;
    logic [msm_pkg::VEL_W-1:0] abs_a, abs_b, abs_c, abs_d;
    logic [msm_pkg::VEL_W-1:0] wmax16;
    logic                      within_max;
    logic                      all_zero;

    // Shadow of wheel_max as seen on the write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wmax <= msm_pkg::RESET_REG;
        end else if (i_cfg_we && (i_cfg_idx == msm_pkg::CFG_WHEEL_MAX)) begin
            r_wmax <= i_cfg_data;
        end
    end

    assign abs_a  = o_result.wheel_a[15] ? -o_result.wheel_a : o_result.wheel_a;
    assign abs_b  = o_result.wheel_b[15] ? -o_result.wheel_b : o_result.wheel_b;
    assign abs_c  = o_result.wheel_c[15] ? -o_result.wheel_c : o_result.wheel_c;
    assign abs_d  = o_result.wheel_d[15] ? -o_result.wheel_d : o_result.wheel_d;
    assign wmax16 = {1'b0, r_wmax};

    assign within_max = (abs_a <= wmax16) && (abs_b <= wmax16) &&
                        (abs_c <= wmax16) && (abs_d <= wmax16);
    assign all_zero   = (o_result.wheel_a == '0) && (o_result.wheel_b == '0) &&
                        (o_result.wheel_c == '0) && (o_result.wheel_d == '0);

    // Every strobe traces back to a command transfer a fixed latency earlier.
    `MSM_ASSERT_NOW(a_done_has_cmd, o_done, $past(start && !busy, msm_pkg::LATENCY), "result without a matching command")
    // Normalisation keeps every wheel within wheel_max.
    `MSM_ASSERT_NOW(a_wheel_in_range, o_done, within_max, "wheel speed above wheel_max")
    // A zero wheel maximum forces every wheel to zero.
    `MSM_ASSERT_NOW(a_zero_max, o_done && (r_wmax == '0), all_zero, "nonzero wheel with zero wheel_max")
    // Reset empties the pipeline.
    `MSM_ASSERT_NEXT(a_reset_quiet, !i_rst_n, !o_done, "strobe straight after reset")

endmodule

bind mecanum_wheel_speed_mixer msm_checker u_msm_checker (.*);
